// ===== rtl/spfa_pkg.sv =====
package spfa_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_MUL = 3'd1;
  localparam logic [2:0] KIND_CMP = 3'd2;
  localparam logic [2:0] KIND_FLT = 3'd3;
  localparam logic [2:0] KIND_FIX = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNF = 2'd2;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;
  localparam logic [31:0] HIDDEN = 32'h0080_0000;
  localparam logic [31:0] CARRY_MASK = 32'hfe00_0000;
  localparam logic [31:0] TOP_BYTE = 32'hff00_0000;
  localparam logic [9:0] BIAS = 10'd127;
  localparam logic [9:0] FLOAT_EXP = 10'd150;
  localparam logic [9:0] FIX_TOP = 10'd157;
  localparam logic [9:0] FIX_LOW = 10'd119;

  // Mantissa with the hidden bit when the exponent field is nonzero.
  function automatic logic [23:0] mant_of(input logic [31:0] w);
    mant_of = {(w[30:23] != 8'd0), w[22:0]};
  endfunction

  // Signed exponent to status code.
  function automatic logic [1:0] exp_status(input logic [9:0] e);
    if (e[9]) begin
      exp_status = ST_UNF;
    end else if (e > 10'd254) begin
      exp_status = ST_OVF;
    end else begin
      exp_status = ST_OK;
    end
  endfunction

endpackage

// ===== rtl/spfa_core.sv =====
module spfa_core import spfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        round_up_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic [1:0]  status_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_NORMR = 3'd3;
  localparam logic [2:0] S_NORML = 3'd4;
  localparam logic [2:0] S_FIXSH = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] kind_q, kind_d;
  logic [63:0] acc_q, acc_d;     // main accumulator / shifting value
  logic [31:0] mb_q, mb_d;       // shifted operand or multiplicand
  logic [23:0] mr_q, mr_d;       // multiplier bits
  logic [9:0] e_q, e_d;
  logic [9:0] cnt_q, cnt_d;
  logic sign_q, sign_d;
  logic sa_q, sa_d, sb_q, sb_d;
  logic rnd_q, rnd_d;
  logic [31:0] res_q, res_d;
  logic [1:0] st_q, st_d;

  logic [9:0] ea, eb, diff;
  logic [31:0] sum32, ma_s, mb_s, neg_in;

  assign ea = {2'b0, operand_a_i[30:23]};
  assign eb = {2'b0, operand_b_i[30:23]};
  assign diff = ea - eb;
  assign neg_in = 32'd0 - operand_a_i;

  // Signed sum used by add and compare after alignment.
  always_comb begin
    if (kind_q == KIND_CMP && rnd_q) begin
      // Swapped compare: acc holds b and mb holds a, so still form a - b.
      ma_s = sb_q ? 32'd0 - mb_q : mb_q;
      mb_s = sa_q ? acc_q[31:0] : 32'd0 - acc_q[31:0];
    end else if (kind_q == KIND_CMP) begin
      ma_s = sa_q ? 32'd0 - acc_q[31:0] : acc_q[31:0];
      mb_s = sb_q ? mb_q : 32'd0 - mb_q;
    end else begin
      ma_s = sa_q ? 32'd0 - acc_q[31:0] : acc_q[31:0];
      mb_s = sb_q ? 32'd0 - mb_q : mb_q;
    end
    sum32 = ma_s + mb_s;
  end

  // Sequencer: one shift or add step per cycle.
  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    acc_d = acc_q;
    mb_d = mb_q;
    mr_d = mr_q;
    e_d = e_q;
    cnt_d = cnt_q;
    sign_d = sign_q;
    sa_d = sa_q;
    sb_d = sb_q;
    rnd_d = rnd_q;
    res_d = res_q;
    st_d = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_i;
          sa_d = operand_a_i[31];
          sb_d = operand_b_i[31];
          rnd_d = round_up_i;
          st_d = ST_OK;
          res_d = 32'd0;
          state_d = S_DONE;
          unique case (kind_i)
            KIND_ADD, KIND_CMP: begin
              // Put the larger-exponent operand unshifted; the count is |d|.
              if (diff[9]) begin
                acc_d = {32'd0, 8'd0, mant_of(operand_b_i)};
                mb_d = {8'd0, mant_of(operand_a_i)};
                sa_d = operand_b_i[31];
                sb_d = operand_a_i[31];
                cnt_d = 10'd0 - diff;
                e_d = eb;
              end else begin
                acc_d = {32'd0, 8'd0, mant_of(operand_a_i)};
                mb_d = {8'd0, mant_of(operand_b_i)};
                cnt_d = diff;
                e_d = ea;
              end
              if (kind_i == KIND_ADD) begin
                acc_d = {acc_d[62:0], 1'b0};
                mb_d = {mb_d[30:0], 1'b0};
              end
              if (diff[9] && kind_i == KIND_CMP) begin
                // Swapped compare: keep roles as a - b by flagging swap in rnd.
                rnd_d = 1'b1;
              end else if (kind_i == KIND_CMP) begin
                rnd_d = 1'b0;
              end
              state_d = S_ALIGN;
            end
            KIND_MUL: begin
              acc_d = 64'd0;
              mb_d = {8'd0, mant_of(operand_a_i)};
              mr_d = mant_of(operand_b_i);
              e_d = ea + eb - BIAS;
              sign_d = operand_a_i[31] ^ operand_b_i[31];
              cnt_d = 10'd24;
              state_d = S_MUL;
            end
            KIND_FLT: begin
              sign_d = operand_a_i[31];
              acc_d = {32'd0, operand_a_i[31] ? neg_in : operand_a_i};
              e_d = FLOAT_EXP;
              if (operand_a_i == 32'd0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_NORMR;
              end
            end
            KIND_FIX: begin
              sign_d = operand_a_i[31];
              if (ea == 10'd0) begin
                res_d = operand_a_i[31] ? 32'd0 - {1'b0, operand_a_i[30:0]}
                                        : {1'b0, operand_a_i[30:0]};
              end else if (ea < FIX_LOW) begin
                res_d = 32'd0;
              end else if (ea > FIX_TOP) begin
                res_d = operand_a_i[31] ? SIGN_BIT : ~SIGN_BIT;
                st_d = ST_OVF;
              end else begin
                acc_d = {32'd0, 1'b1, operand_a_i[22:0], 8'd0};
                cnt_d = FIX_TOP - ea;
                state_d = S_FIXSH;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ALIGN: begin
        // Shift the smaller operand right one bit per cycle (cleared if over 24), then sum.
        if (cnt_q > 10'd24) begin
          mb_d = 32'd0;
          cnt_d = 10'd0;
        end else if (cnt_q != 10'd0) begin
          mb_d = mb_q >> 1;
          cnt_d = cnt_q - 10'd1;
        end else if (kind_q == KIND_CMP) begin
          if (sum32[31]) begin
            res_d = 32'hffff_ffff;
          end else begin
            res_d = (sum32 != 32'd0) ? 32'd1 : 32'd0;
          end
          state_d = S_DONE;
        end else begin
          sign_d = sum32[31];
          acc_d = {32'd0, sum32[31] ? 32'd0 - sum32 : sum32};
          state_d = S_NORMR;
        end
      end
      S_MUL: begin
        // Shift-add: one multiplier bit per cycle, LSB first.
        acc_d = {1'b0, acc_q[63:1]};
        if (mr_q[0]) begin
          acc_d[63:31] = {1'b0, acc_q[63:32]} + {1'b0, mb_q};
        end
        mr_d = mr_q >> 1;
        cnt_d = cnt_q - 10'd1;
        if (cnt_q == 10'd1) begin
          // acc now holds the product shifted left by 8; one more bit gives the <<9 window.
          acc_d = {acc_d[62:0], 1'b0};
          state_d = S_NORMR;
        end
      end
      S_NORMR: begin
        // Right normalize while above the mantissa window.
        if (kind_q == KIND_MUL) begin
          if (acc_q[63:56] != 8'd0) begin
            acc_d = acc_q >> 1;
            e_d = e_q + 10'd1;
          end else if (acc_q == 64'd0) begin
            res_d = {sign_q, 31'd0};
            state_d = S_DONE;
          end else begin
            state_d = S_NORML;
          end
        end else if (kind_q == KIND_FLT) begin
          if ((acc_q[31:0] & TOP_BYTE) != 32'd0) begin
            acc_d = acc_q >> 1;
            e_d = e_q + 10'd1;
          end else begin
            state_d = S_NORML;
          end
        end else begin
          if ((acc_q[31:0] & CARRY_MASK) != 32'd0) begin
            acc_d = acc_q >> 1;
            e_d = e_q + 10'd1;
          end else if (acc_q[31:0] == 32'd0) begin
            res_d = {sign_q, 31'd0};
            state_d = S_DONE;
          end else begin
            state_d = S_NORML;
          end
        end
      end
      S_NORML: begin
        // Left normalize one bit per cycle, then pack.
        if (kind_q == KIND_MUL) begin
          if (!acc_q[55]) begin
            acc_d = acc_q << 1;
            e_d = e_q - 10'd1;
          end else begin
            res_d = {sign_q, e_q[7:0], acc_q[54:32]};
            st_d = exp_status(e_q);
            state_d = S_DONE;
          end
        end else if (kind_q == KIND_FLT) begin
          if (!acc_q[23]) begin
            acc_d = acc_q << 1;
            e_d = e_q - 10'd1;
          end else begin
            res_d = {sign_q, e_q[7:0], acc_q[22:0]};
            state_d = S_DONE;
          end
        end else begin
          if (!acc_q[24]) begin
            acc_d = acc_q << 1;
            e_d = e_q - 10'd1;
          end else begin
            res_d = {sign_q, e_q[7:0], acc_q[23:1]};
            st_d = exp_status(e_q);
            state_d = S_DONE;
          end
        end
      end
      S_FIXSH: begin
        if (cnt_q != 10'd0) begin
          acc_d = acc_q >> 1;
          cnt_d = cnt_q - 10'd1;
        end else begin
          mb_d = (acc_q[31:0] + {31'd0, rnd_q}) >> 1;
          res_d = sign_q ? 32'd0 - ((acc_q[31:0] + {31'd0, rnd_q}) >> 1)
                         : (acc_q[31:0] + {31'd0, rnd_q}) >> 1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    acc_q <= acc_d;
    mb_q <= mb_d;
    mr_q <= mr_d;
    e_q <= e_d;
    cnt_q <= cnt_d;
    sign_q <= sign_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
    rnd_q <= rnd_d;
    res_q <= res_d;
    st_q <= st_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign result_o = res_q;
  assign status_o = st_q;

endmodule

// ===== rtl/single_precision_float_alu.sv =====
// The multiply (24 shift-add steps plus normalization) is the longest operation from the
// accepting edge to the result strobe.
// One request at a time; busy is high through the result strobe cycle,
// so the next request is taken in the cycle after the strobe at the earliest.
// Result appears for one cycle with done_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle.
module single_precision_float_alu import spfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        round_up_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic [1:0]  status_o
);

  // Sequenced datapath.
  spfa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .round_up_i  (round_up_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .status_o    (status_o)
  );

endmodule

// ===== bench/single_precision_float_alu_tb.sv =====
module single_precision_float_alu_tb import spfa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        rnd;
    bit          typed;
    logic [31:0] res;
    logic [1:0]  st;
  } fpu_row_t;

  typedef struct {
    logic [31:0] res;
    logic [1:0]  st;
  } fpu_answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  kind_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        round_up_i;
  logic        done_o;
  logic [31:0] result_o;
  logic [1:0]  status_o;

  fpu_row_t    directed_rows[$];
  fpu_answer_t pending_answers[$];
  int          num_errors;
  int          idle_cycles;
  int          kind_counts[5];
  int          results_seen;

  single_precision_float_alu DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .round_up_i (round_up_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .status_o   (status_o)
  );

  // Clock generator.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mantissa with the implicit one when the exponent field is nonzero.
  function automatic logic [31:0] full_mantissa(input logic [31:0] w);
    full_mantissa = {8'd0, (w[30:23] != 8'd0), w[22:0]};
  endfunction

  function automatic logic [31:0] pack_float(input logic sgn, input int e,
                                             input logic [31:0] m);
    logic [31:0] ev;
    ev = e;
    pack_float = {sgn, ev[7:0], m[22:0]};
  endfunction

  function automatic logic [1:0] exponent_status(input int e);
    if (e > 254) begin
      exponent_status = ST_OVF;
    end else if (e < 0) begin
      exponent_status = ST_UNF;
    end else begin
      exponent_status = ST_OK;
    end
  endfunction

  // Computes the answer the unit must give for one request.
  function automatic fpu_answer_t fpu_answer(input logic [2:0] kind, input logic [31:0] a,
                                             input logic [31:0] b, input logic rnd);
    fpu_answer_t ans;
    int          ea;
    int          eb;
    int          d;
    int          e;
    int          sh;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] sum;
    logic        sgn;
    logic [63:0] prod;
    ans.res = 32'd0;
    ans.st = ST_OK;
    ea = a[30:23];
    eb = b[30:23];
    d = ea - eb;
    case (kind)
      KIND_ADD: begin
        e = ea;
        ma = full_mantissa(a) << 1;
        mb = full_mantissa(b) << 1;
        if (d > 0) begin
          mb = (d > 24) ? 32'd0 : (mb >> d);
        end else if (d < 0) begin
          ma = (d < -24) ? 32'd0 : (ma >> (-d));
          e = eb;
        end
        if (a[31]) ma = -ma;
        if (b[31]) mb = -mb;
        sum = ma + mb;
        sgn = sum[31];
        if (sgn) sum = -sum;
        while ((sum & CARRY_MASK) != 0) begin
          sum = sum >> 1;
          e++;
        end
        if (sum == 0) begin
          ans.res = {sgn, 31'd0};
        end else begin
          while (!sum[24]) begin
            sum = sum << 1;
            e--;
          end
          sum = sum >> 1;
          ans.res = pack_float(sgn, e, sum);
          ans.st = exponent_status(e);
        end
      end
      KIND_MUL: begin
        e = ea + eb - 127;
        sgn = a[31] ^ b[31];
        prod = ({32'd0, full_mantissa(a)} * {32'd0, full_mantissa(b)}) << 9;
        while ((prod >> 56) != 0) begin
          prod = prod >> 1;
          e++;
        end
        if (prod == 0) begin
          ans.res = {sgn, 31'd0};
        end else begin
          while (!prod[55]) begin
            prod = prod << 1;
            e--;
          end
          ans.res = pack_float(sgn, e, prod[63:32]);
          ans.st = exponent_status(e);
        end
      end
      KIND_CMP: begin
        ma = full_mantissa(a);
        mb = full_mantissa(b);
        if (d > 0) begin
          mb = (d > 24) ? 32'd0 : (mb >> d);
        end else if (d < 0) begin
          ma = (d < -24) ? 32'd0 : (ma >> (-d));
        end
        if (a[31]) ma = -ma;
        if (!b[31]) mb = -mb;
        sum = ma + mb;
        if (sum[31]) begin
          ans.res = 32'hffff_ffff;
        end else begin
          ans.res = (sum != 0) ? 32'd1 : 32'd0;
        end
      end
      KIND_FLT: begin
        e = 150;
        sgn = a[31];
        sum = sgn ? -a : a;
        if (sum == 0) begin
          ans.res = {sgn, 31'd0};
        end else begin
          while ((sum & TOP_BYTE) != 0) begin
            sum = sum >> 1;
            e++;
          end
          while ((sum & HIDDEN) == 0) begin
            sum = sum << 1;
            e--;
          end
          ans.res = pack_float(sgn, e, sum);
        end
      end
      KIND_FIX: begin
        sgn = a[31];
        sum = {1'b0, a[30:0]};
        if (ea == 0) begin
          ans.res = sgn ? -sum : sum;
        end else if (ea < 119) begin
          ans.res = 32'd0;
        end else if (ea > 157) begin
          ans.res = sgn ? SIGN_BIT : ~SIGN_BIT;
          ans.st = ST_OVF;
        end else begin
          sum = ((sum & FRAC_MASK) | HIDDEN) << 8;
          sh = 157 - ea;
          sum = (sh > 31) ? 32'd0 : (sum >> sh);
          if (rnd) sum = sum + 1;
          sum = sum >> 1;
          ans.res = sgn ? -sum : sum;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Random float word whose exponent lies in the given range.
  function automatic logic [31:0] random_float(input int emin, input int emax);
    logic [7:0] ex;
    ex = $urandom_range(emax, emin);
    random_float = {$urandom_range(1, 0) == 1, ex, 23'($urandom)};
  endfunction

  task automatic add_row(input logic [2:0] kind, input logic [31:0] a, input logic [31:0] b,
                         input logic rnd, input bit typed, input logic [31:0] res,
                         input logic [1:0] st);
    fpu_row_t r;
    r.kind = kind;
    r.opa = a;
    r.opb = b;
    r.rnd = rnd;
    r.typed = typed;
    r.res = res;
    r.st = st;
    directed_rows.push_back(r);
  endtask

  // Holds one request on the inputs until the unit takes it, then records its answer.
  task automatic issue_request(input fpu_row_t r, input int gap);
    fpu_answer_t ans;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= r.kind;
    operand_a_i <= r.opa;
    operand_b_i <= r.opb;
    round_up_i <= r.rnd;
    do @(posedge clk_i); while (busy);
    if (r.typed) begin
      ans.res = r.res;
      ans.st = r.st;
    end else begin
      ans = fpu_answer(r.kind, r.opa, r.opb, r.rnd);
    end
    pending_answers.push_back(ans);
    if (r.kind < 5) kind_counts[r.kind]++;
  endtask

  // Stimulus: reset, directed table, then three random phases of differing idle rates.
  initial begin
    fpu_row_t r;
    int       phase_idle;
    int       gap;
    num_errors = 0;
    results_seen = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_ADD;
    operand_a_i = 32'd0;
    operand_b_i = 32'd0;
    round_up_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 1'b0, 1, 32'h0000_0000, ST_OK);
    add_row(KIND_ADD, 32'h3f80_0000, 32'hbf80_0000, 1'b0, 1, 32'h0000_0000, ST_OK);
    add_row(KIND_ADD, 32'h3f80_0000, 32'h3f80_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_ADD, 32'h4b00_0000, 32'hbf80_0001, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_ADD, 32'h0080_0000, 32'h8040_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_MUL, 32'h8000_0000, 32'h3f80_0000, 1'b0, 1, 32'h8000_0000, ST_OK);
    add_row(KIND_MUL, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_MUL, 32'h0080_0000, 32'h0080_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_MUL, 32'h3fc0_0000, 32'hc000_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_CMP, 32'h3f80_0000, 32'h3f80_0000, 1'b0, 1, 32'd0, ST_OK);
    add_row(KIND_CMP, 32'h0000_0000, 32'h8000_0000, 1'b0, 1, 32'd0, ST_OK);
    add_row(KIND_CMP, 32'h4000_0000, 32'h3f80_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_CMP, 32'hc000_0000, 32'h3f80_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_CMP, 32'h3f80_0000, 32'h7f80_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_FLT, 32'h0000_0000, 32'hffff_ffff, 1'b0, 1, 32'h0000_0000, ST_OK);
    add_row(KIND_FLT, 32'h8000_0000, 32'h0000_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_FLT, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_FLT, 32'hffff_ffff, 32'h0000_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_FIX, 32'h4f80_0000, 32'h0000_0000, 1'b0, 1, 32'h7fff_ffff, ST_OVF);
    add_row(KIND_FIX, 32'hff80_0000, 32'h0000_0000, 1'b1, 1, 32'h8000_0000, ST_OVF);
    add_row(KIND_FIX, 32'h3a00_0000, 32'h0000_0000, 1'b1, 1, 32'h0000_0000, ST_OK);
    add_row(KIND_FIX, 32'h807f_ffff, 32'h0000_0000, 1'b0, 0, 32'd0, ST_OK);
    add_row(KIND_FIX, 32'h3fc0_0000, 32'h0000_0000, 1'b1, 0, 32'd0, ST_OK);
    add_row(KIND_FIX, 32'hcefe_ffff, 32'h0000_0000, 1'b0, 0, 32'd0, ST_OK);
    foreach (directed_rows[i]) issue_request(directed_rows[i], 0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      phase_idle = (n < NUM_RANDOM / 3) ? 28 : (n < 2 * NUM_RANDOM / 3) ? 61 : 0;
      r.kind = $urandom_range(4, 0);
      r.rnd = $urandom_range(1, 0);
      r.typed = 0;
      // Mostly operands in the ranges where the arithmetic does real work.
      if ($urandom_range(9, 0) < 2) begin
        r.opa = $urandom;
        r.opb = $urandom;
      end else begin
        case (r.kind)
          KIND_ADD, KIND_CMP: begin
            r.opa = random_float(1, 254);
            r.opb = random_float(int'(r.opa[30:23]) > 30 ? int'(r.opa[30:23]) - 30 : 0,
                                 int'(r.opa[30:23]) < 225 ? int'(r.opa[30:23]) + 30 : 255);
            if ($urandom_range(7, 0) == 0) r.opb = r.opa ^ {$urandom_range(1, 0) == 1, 31'd0};
          end
          KIND_MUL: begin
            r.opa = random_float(60, 195);
            r.opb = random_float(60, 195);
          end
          KIND_FLT: begin
            r.opa = $urandom >> $urandom_range(31, 0);
            if ($urandom_range(1, 0) == 1) r.opa = -r.opa;
          end
          default: begin
            r.opa = random_float(115, 160);
            r.opb = $urandom;
          end
        endcase
      end
      gap = ($urandom_range(99, 0) < phase_idle) ? $urandom_range(6, 1) : 0;
      issue_request(r, gap);
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d adds, %0d multiplies, %0d compares, %0d int-to-float, %0d float-to-int,",
             kind_counts[0], kind_counts[1], kind_counts[2], kind_counts[3], kind_counts[4]);
    $display("with %0d results checked across idle rates of 28, 61 and 0 percent.", results_seen);
    if (num_errors == 0) begin
      $display("PASS single_precision_float_alu");
    end else begin
      $display("FAIL single_precision_float_alu");
    end
    $finish;
  end

  // Compares each result strobe with the oldest outstanding answer.
  always @(posedge clk_i) begin
    fpu_answer_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result 0x%08h status %0d with no request outstanding", result_o, status_o);
        num_errors++;
      end else begin
        want = pending_answers.pop_front();
        if (result_o !== want.res) begin
          $error("result: expected 0x%08h, got 0x%08h", want.res, result_o);
          num_errors++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status_o);
          num_errors++;
        end
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL single_precision_float_alu");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
